@@ hdl/cmpb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cmpb_pkg
// shared codes and controller/datapath handshake types for the cursor
// mask plane builder
// ---------------------------------------------------------------------------
package cmpb_pkg;

  // item operation codes (func field)
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_PIXEL = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ALPHA_MODE   = 2'd2;

  // source of a read result
  localparam logic [1:0] RSEL_AND  = 2'd0;
  localparam logic [1:0] RSEL_XOR  = 2'd1;
  localparam logic [1:0] RSEL_ZERO = 2'd2;

  // luma weights and thresholds
  localparam logic [7:0] LUMA_R      = 8'd77;
  localparam logic [7:0] LUMA_G      = 8'd150;
  localparam logic [7:0] LUMA_B      = 8'd29;
  localparam logic [7:0] LUMA_DARK   = 8'd128;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // controller to datapath
  typedef struct packed {
    logic accept;       // input transfer this cycle
    logic clear_step;   // write one transparent byte pair at the sweep pointer
    logic pixel_write;  // write back the modified byte pair of a pixel
    logic read_load;    // move the read byte into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;   // sweep pointer at the last byte
    logic out_free;     // output register can take a byte this cycle
  } dp_status_t;

endpackage
`default_nettype wire

@@ hdl/cursor_mask_plane_builder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cursor_mask_plane_builder
// monochrome cursor image builder holding an and plane and an xor plane,
// with pixel writes, whole-image clear and byte reads
// ---------------------------------------------------------------------------
// sequence: a pixel write reads both planes at the input transfer, then writes
//   back both planes; a read waits until the output register is free, loads its
//   byte there and shows it the cycle after; a clear writes one byte pair per
//   cycle through the single ram write port
// reset: synchronous, active high; after reset a clearing pass over all
//   PLANE_BYTES byte pairs (512 at the default size) makes the image transparent
//   before the first input transfer; configuration writes are taken at once
// ---------------------------------------------------------------------------
module cursor_mask_plane_builder
  import cmpb_pkg::*;
#(
  parameter int CURSOR_SIZE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data,
  // item input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // func[1:0], pixel_row[7:2], pixel_column[13:8], red[21:14], green[29:22],
  // blue[37:30], alpha[45:38], byte_address[55:46]
  input  wire logic [55:0] s_tdata,
  // result output
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // read_data[7:0]
  output logic [7:0]       m_tdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: one item at a time, ready only when idle
  cmpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tdata[1:0]),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: address and luma decode at transfer, plane rams, output stage
  cmpb_dp #(.CURSOR_SIZE(CURSOR_SIZE)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (s_tdata[1:0]),
    .pixel_row    (s_tdata[7:2]),
    .pixel_column (s_tdata[13:8]),
    .red          (s_tdata[21:14]),
    .green        (s_tdata[29:22]),
    .blue         (s_tdata[37:30]),
    .alpha        (s_tdata[45:38]),
    .byte_address (s_tdata[55:46]),
    .cmd          (cmd),
    .status       (status),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule
`default_nettype wire

@@ hdl/cmpb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cmpb_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module cmpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/cmpb_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cmpb_dp
// datapath: config registers, pixel decode, plane rams, clear sweep
// pointer and output register
// ---------------------------------------------------------------------------
module cmpb_dp
  import cmpb_pkg::*;
#(
  parameter int CURSOR_SIZE = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  input  wire logic [1:0] func,
  input  wire logic [5:0] pixel_row,
  input  wire logic [5:0] pixel_column,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire logic [7:0] alpha,
  input  wire logic [9:0] byte_address,
  input  wire ctrl_cmd_t  cmd,
  output dp_status_t      status,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata
);

  localparam int ROW_BYTES   = (CURSOR_SIZE + 7) / 8;
  localparam int PLANE_BYTES = ROW_BYTES * CURSOR_SIZE;
  localparam int AW          = $clog2(PLANE_BYTES);
  localparam int LW          = (AW > 10 ? AW : 10) + 2;
  localparam int CW          = $clog2(CURSOR_SIZE + 1);
  localparam int PW          = (CW > 7 ? CW : 7);

  // configuration
  logic [6:0] image_width;
  logic [6:0] image_height;
  logic       alpha_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 7'd64;
      image_height <= 7'd64;
      alpha_mode   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_ALPHA_MODE:   alpha_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pixel decode
  logic [7:0]    eff_alpha;
  logic          hit;
  logic [15:0]   luma_sum;
  logic          dark;
  logic [LW-1:0] pix_idx;
  logic [LW-1:0] rd_addr;
  logic [LW-1:0] rd_off;
  logic [1:0]    rd_sel;
  logic [AW-1:0] raddr;

  assign eff_alpha = alpha_mode ? alpha : ALPHA_OPAQUE;
  assign hit = eff_alpha[7]
             && ({1'b0, pixel_column} < image_width)
             && ({1'b0, pixel_row} < image_height)
             && (PW'(pixel_column) < PW'(CURSOR_SIZE))
             && (PW'(pixel_row) < PW'(CURSOR_SIZE));
  assign luma_sum = 16'(red * LUMA_R) + 16'(green * LUMA_G) + 16'(blue * LUMA_B);
  assign dark     = luma_sum[15:8] <= LUMA_DARK;
  assign pix_idx  = LW'(pixel_row) * LW'(ROW_BYTES) + LW'(pixel_column[5:3]);

  assign rd_addr = LW'(byte_address);
  always_comb begin
    if (rd_addr < LW'(PLANE_BYTES)) begin
      rd_sel = RSEL_AND;
      rd_off = rd_addr;
    end else if (rd_addr < LW'(2 * PLANE_BYTES)) begin
      rd_sel = RSEL_XOR;
      rd_off = rd_addr - LW'(PLANE_BYTES);
    end else begin
      rd_sel = RSEL_ZERO;
      rd_off = '0;
    end
  end

  assign raddr = (func == FUNC_READ) ? rd_off[AW-1:0] : pix_idx[AW-1:0];

  // item registers, taken on accept
  logic          hit_q;
  logic          dark_q;
  logic [7:0]    mask_q;
  logic [AW-1:0] waddr_q;
  logic [1:0]    rsel_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hit_q   <= hit;
      dark_q  <= dark;
      mask_q  <= 8'h80 >> pixel_column[2:0];
      waddr_q <= pix_idx[AW-1:0];
      rsel_q  <= rd_sel;
    end
  end

  // clear sweep pointer
  logic [AW-1:0] clr_count;

  assign status.clear_done = clr_count == AW'(PLANE_BYTES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_count <= '0;
    end else if (cmd.clear_step) begin
      clr_count <= status.clear_done ? '0 : clr_count + 1'b1;
    end
  end

  // plane rams
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    and_wdata;
  logic [7:0]    xor_wdata;
  logic [7:0]    and_rdata;
  logic [7:0]    xor_rdata;

  assign we    = cmd.clear_step || (cmd.pixel_write && hit_q);
  assign waddr = cmd.clear_step ? clr_count : waddr_q;

  always_comb begin
    if (cmd.clear_step) begin
      and_wdata = 8'hFF;
      xor_wdata = 8'h00;
    end else begin
      and_wdata = and_rdata & ~mask_q;
      xor_wdata = dark_q ? (xor_rdata | mask_q) : (xor_rdata & ~mask_q);
    end
  end

  cmpb_ram #(.WIDTH(8), .DEPTH(PLANE_BYTES)) u_and_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (and_wdata),
    .re    (cmd.accept),
    .raddr (raddr),
    .rdata (and_rdata)
  );

  cmpb_ram #(.WIDTH(8), .DEPTH(PLANE_BYTES)) u_xor_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (xor_wdata),
    .re    (cmd.accept),
    .raddr (raddr),
    .rdata (xor_rdata)
  );

  // output register
  logic [7:0] rd_byte;

  always_comb begin
    case (rsel_q)
      RSEL_AND: rd_byte = and_rdata;
      RSEL_XOR: rd_byte = xor_rdata;
      default:  rd_byte = 8'h00;
    endcase
  end

  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.read_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_load) begin
      m_tdata <= rd_byte;
    end
  end

endmodule
`default_nettype wire

@@ hdl/cmpb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cmpb_ctrl
// item sequencer: clear sweep, pixel read-modify-write, byte read
// ---------------------------------------------------------------------------
module cmpb_ctrl
  import cmpb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [1:0] func,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_PIXEL = 4'b0100,
    ST_READ  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = state == ST_IDLE;

  always_comb begin
    state_next      = state;
    cmd.accept      = 1'b0;
    cmd.clear_step  = 1'b0;
    cmd.pixel_write = 1'b0;
    cmd.read_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          case (func)
            FUNC_CLEAR: state_next = ST_CLEAR;
            FUNC_PIXEL: state_next = ST_PIXEL;
            FUNC_READ:  state_next = ST_READ;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_PIXEL: begin
        cmd.pixel_write = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_READ: begin
        if (status.out_free) begin
          cmd.read_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire
